/* hw/rtl/rfa_pkg.sv */
// Package: operation codes, sequencer states and result widths for the fraction ALU.
`default_nettype none
package rfa_pkg;
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 31;
  localparam int REQ_W     = 3;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_MUL    = 3'd2,
    OP_DIV    = 3'd3,
    OP_REDUCE = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMB,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

/* hw/rtl/rfa_if.sv */
// Valid/ready channel interfaces carrying the fraction ALU request and result payloads.
`default_nettype none
interface rfa_in_if #(parameter int DW = 16) ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           req_type;
  logic signed [DW-1:0] a_num;
  logic signed [DW-1:0] a_den;
  logic signed [DW-1:0] b_num;
  logic signed [DW-1:0] b_den;
  modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rfa_out_if ();
  logic               valid;
  logic               ready;
  logic signed [32:0] res_num;
  logic [30:0]        res_den;
  logic               status;
  modport source (output valid, res_num, res_den, status, input ready);
  modport sink (input valid, res_num, res_den, status, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rational_fraction_alu.sv */
// Top level: rational fraction ALU with Euclid gcd reduction on a shared divider.
`default_nettype none
// Takes one transaction of two signed fractions and an operation (add, subtract,
// multiply, divide, reduce a) and returns the reduced fraction with a positive
// denominator, or 0/1 with status 1 on a zero denominator, division by a zero
// fraction or an unknown operation. One transaction at a time: in_ready is high
// only while the sequencer is idle. All work runs on shared hardware: a single
// multiplier forms the cross products one per cycle, then one restoring divider
// that loads its operands and then retires one quotient/remainder bit per cycle
// does every Euclid remainder step and the two final divisions by the gcd. The
// result sits in an output register until out_ready takes it.
module rational_fraction_alu
  import rfa_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  rfa_in_if.sink   in_ch,
  rfa_out_if.source out_ch
);
  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW + 1;           // magnitude width of products and sums
  localparam int CW = $clog2(PW + 1);

  state_t state_r, state_nxt;

  // sign-magnitude operands
  logic          an_s_r, ad_s_r, bn_s_r, bd_s_r;
  logic [DW-1:0] an_m_r, ad_m_r, bn_m_r, bd_m_r;
  logic [2:0]    op_r;
  logic [1:0]    mstep_r, mstep_nxt;
  logic [PW-1:0] p0_r, p1_r, p2_r;          // products
  logic          p0_s_r, p1_s_r, p2_s_r;
  logic [PW-1:0] num_r, den_r;              // unreduced result magnitudes
  logic          neg_r;
  logic [PW-1:0] gx_r, gy_r;                // Euclid pair
  // shared restoring divider
  logic [PW-1:0] dvd_r, dvs_r, quo_r, rem_r;
  logic [CW-1:0] cnt_r;
  logic          dbusy_r;
  logic [PW-1:0] nq_r;
  logic [32:0]   res_num_r;
  logic [30:0]   res_den_r;
  logic          status_r, ovalid_r;

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
    mag = v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  // shared multiplier: operand select by step
  // multiply: an*bn, ad*bd; divide: an*bd, bn*ad; add/sub: an*bd, bn*ad, ad*bd
  logic [DW-1:0]   mx, my;
  logic [2*DW-1:0] mprod;
  always_comb begin
    case (mstep_r)
      2'd0:    begin mx = an_m_r; my = (op_r == OP_MUL) ? bn_m_r : bd_m_r; end
      2'd1:    begin
        mx = (op_r == OP_MUL) ? ad_m_r : bn_m_r;
        my = (op_r == OP_MUL) ? bd_m_r : ad_m_r;
      end
      default: begin mx = ad_m_r; my = bd_m_r; end
    endcase
    mprod = mx * my;
  end

  // one divider step
  logic [PW:0]   trem;
  logic          tge;
  always_comb begin
    trem = {rem_r, dvd_r[PW-1]};
    tge  = trem >= {1'b0, dvs_r};
  end

  logic in_acc, err;
  assign in_ch.ready = (state_r == ST_IDLE) && !ovalid_r;
  assign in_acc = in_ch.valid && in_ch.ready;
  always_comb begin
    err = (in_ch.req_type > OP_REDUCE) || (in_ch.a_den == '0) ||
          ((in_ch.req_type != OP_REDUCE) && (in_ch.b_den == '0)) ||
          ((in_ch.req_type == OP_DIV) && (in_ch.b_num == '0));
  end

  // signed combine of two products
  logic          cs1;
  logic [PW-1:0] cnum;
  logic          cneg;
  always_comb begin
    cs1 = (op_r == OP_SUB) ? !p1_s_r : p1_s_r;
    if (p0_s_r == cs1) begin
      cnum = p0_r + p1_r; cneg = p0_s_r;
    end else if (p0_r >= p1_r) begin
      cnum = p0_r - p1_r; cneg = p0_s_r;
    end else begin
      cnum = p1_r - p0_r; cneg = cs1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mstep_nxt = mstep_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) begin
        if (err) state_nxt = ST_OUT;
        else if (in_ch.req_type == OP_REDUCE) state_nxt = ST_COMB;
        else state_nxt = ST_MUL;
        mstep_nxt = 2'd0;
      end
      ST_MUL: begin
        if ((op_r == OP_MUL || op_r == OP_DIV) ? (mstep_r == 2'd1) : (mstep_r == 2'd2))
          state_nxt = ST_COMB;
        mstep_nxt = mstep_r + 2'd1;
      end
      ST_COMB: state_nxt = ST_GCD;
      ST_GCD:  if (!dbusy_r && gy_r == '0) state_nxt = ST_DIVN;
      ST_DIVN: if (dbusy_r && cnt_r == '0) state_nxt = ST_DIVD;
      ST_DIVD: if (dbusy_r && cnt_r == '0) state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      mstep_r  <= 2'd0;
      dbusy_r  <= 1'b0;
      ovalid_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      mstep_r <= mstep_nxt;
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      // divider start/step, shared by Euclid and the final divisions
      if (dbusy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) dbusy_r <= 1'b0;
      end else if ((state_r == ST_GCD && gy_r != '0) ||
                   (state_r == ST_DIVN) || (state_r == ST_DIVD)) begin
        dbusy_r <= 1'b1;
        cnt_r   <= CW'(PW - 1);
      end
      if (state_r == ST_OUT) ovalid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_ch.req_type;
      an_s_r <= in_ch.a_num[DW-1]; an_m_r <= mag(in_ch.a_num);
      ad_s_r <= in_ch.a_den[DW-1]; ad_m_r <= mag(in_ch.a_den);
      bn_s_r <= in_ch.b_num[DW-1]; bn_m_r <= mag(in_ch.b_num);
      bd_s_r <= in_ch.b_den[DW-1]; bd_m_r <= mag(in_ch.b_den);
      num_r  <= '0;
      status_r <= err;
    end
    if (state_r == ST_MUL) begin
      unique case (mstep_r)
        2'd0: begin p0_r <= PW'(mprod);
          p0_s_r <= an_s_r ^ ((op_r == OP_MUL) ? bn_s_r : bd_s_r); end
        2'd1: begin p1_r <= PW'(mprod);
          p1_s_r <= (op_r == OP_MUL) ? (ad_s_r ^ bd_s_r) : (bn_s_r ^ ad_s_r); end
        default: begin p2_r <= PW'(mprod); p2_s_r <= ad_s_r ^ bd_s_r; end
      endcase
    end
    if (state_r == ST_COMB) begin
      if (op_r == OP_REDUCE) begin
        num_r <= PW'(an_m_r); den_r <= PW'(ad_m_r); neg_r <= an_s_r ^ ad_s_r;
        gx_r  <= PW'(an_m_r); gy_r  <= PW'(ad_m_r);
      end else if (op_r == OP_MUL || op_r == OP_DIV) begin
        num_r <= p0_r; den_r <= p1_r; neg_r <= p0_s_r ^ p1_s_r;
        gx_r  <= p0_r; gy_r  <= p1_r;
      end else begin
        num_r <= cnum; den_r <= p2_r; neg_r <= cneg ^ p2_s_r;
        gx_r  <= cnum; gy_r  <= p2_r;
      end
    end
    // divider
    if (dbusy_r) begin
      dvd_r <= {dvd_r[PW-2:0], 1'b0};
      quo_r <= {quo_r[PW-2:0], tge};
      rem_r <= tge ? PW'(trem - {1'b0, dvs_r}) : trem[PW-1:0];
      if (cnt_r == '0) begin
        if (state_r == ST_GCD) begin
          gx_r <= gy_r;
          gy_r <= tge ? PW'(trem - {1'b0, dvs_r}) : trem[PW-1:0];
        end else if (state_r == ST_DIVN) begin
          nq_r <= {quo_r[PW-2:0], tge};
        end
      end
    end else if (state_r == ST_GCD && gy_r != '0) begin
      dvd_r <= gx_r; dvs_r <= gy_r; rem_r <= '0; quo_r <= '0;
    end else if (state_r == ST_DIVN) begin
      dvd_r <= num_r; dvs_r <= gx_r; rem_r <= '0; quo_r <= '0;
    end else if (state_r == ST_DIVD) begin
      dvd_r <= den_r; dvs_r <= gx_r; rem_r <= '0; quo_r <= '0;
    end
    if (state_r == ST_OUT) begin
      if (status_r || num_r == '0) begin
        res_num_r <= '0; res_den_r <= 31'd1;
      end else begin
        res_num_r <= neg_r ? 33'(-{1'b0, nq_r}) : 33'(nq_r);
        res_den_r <= 31'(quo_r);
      end
    end
  end

  assign out_ch.valid   = ovalid_r;
  assign out_ch.res_num = res_num_r;
  assign out_ch.res_den = res_den_r;
  assign out_ch.status  = status_r;

  // never accept while a result is pending
  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> !in_ch.ready) else $error("accept while result pending");
  // divider runs only in its three states
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    dbusy_r |-> (state_r == ST_GCD || state_r == ST_DIVN || state_r == ST_DIVD))
    else $error("divider busy outside division states");
  // result appears right after output state
  a_out_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |=> ovalid_r) else $error("result not posted");
endmodule
`default_nettype wire
